// ----- src/npc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the near-plane clip and projection unit.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [15:0] src;
  } vtx_t;

  // One vertex to emit: a plain vertex (cut low) or the point on from->to
  // at the near plane.
  typedef struct packed {
    vtx_t from_v;
    vtx_t to_v;
    logic cut;
    logic last;
  } job_t;

  typedef struct packed {
    logic [31:0] focal;
    logic [13:0] width;
    logic [13:0] height;
    logic [30:0] nearv;   // effective near plane, never zero
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLEND,
    S_LERP,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_PUSH
  } back_state_t;

endpackage
`default_nettype wire

// ----- src/npc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_in_if / npc_out_if
// Valid/ready channels for triangles in and projected vertices out.
// ----------------------------------------------------------------------------
interface npc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos0_x;
  logic signed [31:0] pos0_y;
  logic signed [31:0] pos0_z;
  logic signed [31:0] pos1_x;
  logic signed [31:0] pos1_y;
  logic signed [31:0] pos1_z;
  logic signed [31:0] pos2_x;
  logic signed [31:0] pos2_y;
  logic signed [31:0] pos2_z;
  logic        [15:0] source0;
  logic        [15:0] source1;
  logic        [15:0] source2;

  modport source (output valid, pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z,
                  pos2_x, pos2_y, pos2_z, source0, source1, source2,
                  input ready);
  modport sink (input valid, pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z,
                pos2_x, pos2_y, pos2_z, source0, source1, source2,
                output ready);
endinterface

interface npc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic        [30:0] depth;
  logic        [15:0] from_index;
  logic        [15:0] to_index;
  logic        [16:0] blend;
  logic               last;

  modport source (output valid, screen_x, screen_y, depth, from_index, to_index,
                  blend, last, input ready);
  modport sink (input valid, screen_x, screen_y, depth, from_index, to_index,
                blend, last, output ready);
endinterface
`default_nettype wire

// ----- src/npc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_front
// Takes a triangle, classifies its vertices against the near plane and
// issues one vertex job per cycle into the job queue while it is not full.
// ----------------------------------------------------------------------------
module npc_front #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  npc_in_if.sink            in_ch,
  input  wire logic [30:0]  nearv,
  output npc_pkg::job_t     q_data,
  output logic              q_push,
  input  wire logic         q_full
);
  import npc_pkg::*;

  localparam logic [15:0] IdxMask =
    (INDEX_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << INDEX_BITS) - 64'd1);

  typedef struct packed {
    logic [1:0] f;
    logic [1:0] t;
    logic       cut;
    logic       last;
  } sel_t;

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    nxt3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  // mode: number of clipped vertices; c: first clipped (one) or kept (two)
  function automatic sel_t pick(input logic [1:0] mode, input logic [1:0] c,
                                input logic [2:0] step);
    sel_t s;
    logic [1:0] a;
    logic [1:0] b;
    a = nxt3(c);
    b = nxt3(a);
    s = '0;
    case (mode)
      2'd0: begin
        s.f = step[1:0]; s.t = step[1:0]; s.last = (step == 3'd2);
      end
      2'd1: begin
        case (step)
          3'd0:    begin s.f = c; s.t = a; s.cut = 1'b1; end
          3'd1:    begin s.f = a; s.t = a; end
          3'd2:    begin s.f = b; s.t = b; end
          3'd3:    begin s.f = c; s.t = a; s.cut = 1'b1; end
          3'd4:    begin s.f = b; s.t = b; end
          default: begin s.f = c; s.t = b; s.cut = 1'b1; s.last = 1'b1; end
        endcase
      end
      default: begin
        case (step)
          3'd0:    begin s.f = c; s.t = c; end
          3'd1:    begin s.f = c; s.t = a; s.cut = 1'b1; end
          default: begin s.f = c; s.t = b; s.cut = 1'b1; s.last = 1'b1; end
        endcase
      end
    endcase
    return s;
  endfunction

  vtx_t       v_r [3];
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] c_r, c_nxt;
  logic [2:0] step_r, step_nxt;
  logic       busy_r, busy_nxt;

  vtx_t       vin [3];
  logic [2:0] clip;
  logic [1:0] cnt;
  logic       accept;
  logic       last_push;
  sel_t       sel;

  always_comb begin
    vin[0] = '{in_ch.pos0_x, in_ch.pos0_y, in_ch.pos0_z, in_ch.source0 & IdxMask};
    vin[1] = '{in_ch.pos1_x, in_ch.pos1_y, in_ch.pos1_z, in_ch.source1 & IdxMask};
    vin[2] = '{in_ch.pos2_x, in_ch.pos2_y, in_ch.pos2_z, in_ch.source2 & IdxMask};
    for (int i = 0; i < 3; i++) begin
      clip[i] = $signed({vin[i].z[31], vin[i].z}) <= $signed({2'b00, nearv});
    end
    cnt = 2'({1'b0, clip[0]} + {1'b0, clip[1]} + {1'b0, clip[2]});
  end

  assign sel       = pick(mode_r, c_r, step_r);
  assign q_push    = busy_r && !q_full;
  assign last_push = q_push && sel.last;
  assign in_ch.ready = !busy_r || last_push;
  assign accept    = in_ch.valid && in_ch.ready;

  assign q_data.from_v = v_r[sel.f];
  assign q_data.to_v   = v_r[sel.t];
  assign q_data.cut    = sel.cut;
  assign q_data.last   = sel.last;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    mode_nxt = mode_r;
    c_nxt    = c_r;
    if (q_push) begin
      step_nxt = step_r + 3'd1;
      if (sel.last) busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = (cnt != 2'd3);
      step_nxt = '0;
      mode_nxt = cnt;
      if (cnt == 2'd1) begin
        c_nxt = clip[0] ? 2'd0 : (clip[1] ? 2'd1 : 2'd2);
      end else begin
        c_nxt = !clip[0] ? 2'd0 : (!clip[1] ? 2'd1 : 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    c_r    <= c_nxt;
    if (accept) begin
      for (int i = 0; i < 3; i++) v_r[i] <= vin[i];
    end
  end

endmodule
`default_nettype wire

// ----- src/npc_job_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_job_queue
// Small FIFO of vertex jobs between the front and the back.
// ----------------------------------------------------------------------------
module npc_job_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire npc_pkg::job_t  wr_data,
  input  wire logic           push,
  output logic                full,
  output npc_pkg::job_t       rd_data,
  input  wire logic           pop,
  output logic                empty
);
  import npc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;

  assign full    = (cnt_r == (PtrW+1)'(QueueDepth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ----- src/npc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_back
// Per-vertex sequencer: blend divide (cut jobs only), interpolate, scale,
// bit-serial perspective divide, then the output register.
// ----------------------------------------------------------------------------
module npc_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire npc_pkg::cfg_t cfg,
  input  wire npc_pkg::job_t q_data,
  input  wire logic          q_empty,
  output logic               q_pop,
  npc_out_if.source          out_ch
);
  import npc_pkg::*;

  localparam logic [40:0] QMax = 41'd1 << 40;

  back_state_t        state_r, state_nxt;
  logic [5:0]         cnt_r;
  job_t               job_r;
  logic [32:0]        den_r;
  logic [32:0]        brem_r;
  logic [16:0]        blow_r;
  logic [16:0]        blend_r;
  logic signed [31:0] vx_r, vy_r;
  logic [30:0]        z_r;
  logic               negx_r, negy_r;
  logic [63:0]        px_r, py_r;
  logic [31:0]        rx_r, ry_r;
  logic [40:0]        lx_r, ly_r;
  logic [40:0]        qx_r, qy_r;
  logic               satx_r, saty_r;
  logic               ov_r;
  logic signed [31:0] osx_r, osy_r;
  logic [30:0]        odep_r;
  logic [15:0]        ofrom_r, oto_r;
  logic [16:0]        oblend_r;
  logic               olast_r;

  // blend divide setup
  logic signed [33:0] ndiff, ddiff;
  logic [32:0]        num, den;
  always_comb begin
    ndiff = $signed({3'b000, cfg.nearv}) - 34'(q_data.from_v.z);
    ddiff = 34'(q_data.to_v.z) - 34'(q_data.from_v.z);
    num   = ndiff[33] ? 33'(-ndiff) : ndiff[32:0];
    den   = ddiff[33] ? 33'(-ddiff) : ddiff[32:0];
  end

  logic [33:0] btrial;
  logic        bge;
  assign btrial = {brem_r, blow_r[16]};
  assign bge    = btrial >= {1'b0, den_r};

  // interpolation
  logic signed [32:0] dx, dy;
  logic signed [50:0] mx, my;
  assign dx = 33'(job_r.to_v.x) - 33'(job_r.from_v.x);
  assign dy = 33'(job_r.to_v.y) - 33'(job_r.from_v.y);
  assign mx = 51'(dx) * $signed({34'd0, blend_r});
  assign my = 51'(dy) * $signed({34'd0, blend_r});

  logic signed [50:0] shx, shy;
  assign shx = mx >>> 16;
  assign shy = my >>> 16;

  // magnitudes for scaling
  logic [31:0] magx, magy;
  assign magx = vx_r[31] ? 32'(-vx_r) : vx_r;
  assign magy = vy_r[31] ? 32'(-vy_r) : vy_r;

  // perspective divide, one quotient bit per cycle on each axis
  logic [31:0] xtrial, ytrial;
  logic        xge, yge;
  assign xtrial = {rx_r[30:0], lx_r[40]};
  assign ytrial = {ry_r[30:0], ly_r[40]};
  assign xge    = xtrial >= {1'b0, z_r};
  assign yge    = ytrial >= {1'b0, z_r};

  // final assembly
  logic [40:0]        fqx, fqy;
  logic signed [43:0] hw, hh, sx, sy;
  logic signed [31:0] satsx, satsy;
  logic               out_free;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647)       sat32 = 32'sh7FFFFFFF;
    else if (v < -44'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

  always_comb begin
    fqx   = (satx_r || qx_r > QMax) ? QMax : qx_r;
    fqy   = (saty_r || qy_r > QMax) ? QMax : qy_r;
    hw    = $signed(44'(cfg.width) << (FRAC_BITS - 1));
    hh    = $signed(44'(cfg.height) << (FRAC_BITS - 1));
    sx    = negx_r ? hw - $signed(44'(fqx)) : hw + $signed(44'(fqx));
    sy    = negy_r ? hh + $signed(44'(fqy)) : hh - $signed(44'(fqy));
    satsx = sat32(sx);
    satsy = sat32(sy);
  end

  assign out_free = !ov_r || out_ch.ready;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = q_data.cut ? S_BLEND : S_LERP;
      S_BLEND: if (cnt_r == '0) state_nxt = S_LERP;
      S_LERP:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DINIT;
      S_DINIT: state_nxt = S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_PUSH;
      S_PUSH:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PUSH && out_free) ov_r <= 1'b1;
      else if (out_ch.ready)             ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        job_r   <= q_data;
        den_r   <= den;
        brem_r  <= {1'b0, num[32:1]};
        blow_r  <= {num[0], 16'd0};
        blend_r <= '0;
        cnt_r   <= 6'd16;
      end
      S_BLEND: begin
        brem_r  <= bge ? 33'(btrial - {1'b0, den_r}) : btrial[32:0];
        blow_r  <= {blow_r[15:0], 1'b0};
        blend_r <= {blend_r[15:0], bge};
        cnt_r   <= cnt_r - 6'd1;
      end
      S_LERP: begin
        vx_r <= job_r.from_v.x + shx[31:0];
        vy_r <= job_r.from_v.y + shy[31:0];
        z_r  <= job_r.cut ? cfg.nearv : job_r.from_v.z[30:0];
      end
      S_MUL: begin
        negx_r <= vx_r[31];
        negy_r <= vy_r[31];
        px_r   <= 64'(magx) * 64'(cfg.focal);
        py_r   <= 64'(magy) * 64'(cfg.focal);
      end
      S_DINIT: begin
        satx_r <= {9'd0, px_r[63:41]} >= {1'b0, z_r};
        saty_r <= {9'd0, py_r[63:41]} >= {1'b0, z_r};
        rx_r   <= {9'd0, px_r[63:41]};
        ry_r   <= {9'd0, py_r[63:41]};
        lx_r   <= px_r[40:0];
        ly_r   <= py_r[40:0];
        qx_r   <= '0;
        qy_r   <= '0;
        cnt_r  <= 6'd40;
      end
      S_DIV: begin
        rx_r  <= xge ? xtrial - {1'b0, z_r} : xtrial;
        ry_r  <= yge ? ytrial - {1'b0, z_r} : ytrial;
        lx_r  <= {lx_r[39:0], 1'b0};
        ly_r  <= {ly_r[39:0], 1'b0};
        qx_r  <= {qx_r[39:0], xge};
        qy_r  <= {qy_r[39:0], yge};
        cnt_r <= cnt_r - 6'd1;
      end
      S_PUSH: begin
        if (out_free) begin
          osx_r    <= satsx;
          osy_r    <= satsy;
          odep_r   <= z_r;
          ofrom_r  <= job_r.from_v.src;
          oto_r    <= job_r.cut ? job_r.to_v.src : job_r.from_v.src;
          oblend_r <= blend_r;
          olast_r  <= job_r.last;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.screen_x   = osx_r;
  assign out_ch.screen_y   = osy_r;
  assign out_ch.depth      = odep_r;
  assign out_ch.from_index = ofrom_r;
  assign out_ch.to_index   = oto_r;
  assign out_ch.blend      = oblend_r;
  assign out_ch.last       = olast_r;

`ifndef SYNTHESIS
  a_blend_only_cut: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLEND) |-> job_r.cut)
    else $error("blend divide on a plain vertex");
  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LERP) |-> (blend_r <= 17'd65536))
    else $error("blend out of range");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_PUSH))
    else $error("divide did not end in push");
  a_plain_blend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && !job_r.cut) |-> (blend_r == '0))
    else $error("plain vertex with nonzero blend");
`endif

endmodule
`default_nettype wire

// ----- src/near_plane_clip_project_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// near_plane_clip_project_unit
// Near-plane triangle clipper with perspective projection to screen space.
// ----------------------------------------------------------------------------
// A triangle is accepted when the front is free; it then issues its 0, 3
// or 6 vertex jobs into a four-entry queue at one per cycle while the queue
// has room, and can take the next triangle on the cycle its last job enters
// the queue. The back handles one vertex at a time, using a bit-serial blend
// divider (17 steps) for a near-plane intersection only and two parallel
// perspective dividers (41 steps each) for every vertex. A finished vertex
// sits in the output register while the back starts the next one. Registers
// (APB, byte address 4*i): focal_scale, screen_width, screen_height,
// near_plane; a near_plane of zero acts as one LSB. Write them only while
// the unit is idle.
// ----------------------------------------------------------------------------
module near_plane_clip_project_unit #(
  parameter int INDEX_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  npc_in_if.sink           in_ch,
  npc_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import npc_pkg::*;

  localparam logic [1:0] RegFocal  = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;
  localparam logic [1:0] RegNear   = 2'd3;

  logic [31:0] focal_r;
  logic [13:0] width_r;
  logic [13:0] height_r;
  logic [30:0] near_r;
  logic        wr_en;
  cfg_t        cfg;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= 32'd40861696;
      width_r  <= 14'd1280;
      height_r <= 14'd720;
      near_r   <= 31'd655;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        RegFocal:  focal_r  <= cfg_pwdata;
        RegWidth:  width_r  <= cfg_pwdata[13:0];
        RegHeight: height_r <= cfg_pwdata[13:0];
        RegNear:   near_r   <= cfg_pwdata[30:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      RegFocal:  cfg_prdata = focal_r;
      RegWidth:  cfg_prdata = {18'd0, width_r};
      RegHeight: cfg_prdata = {18'd0, height_r};
      RegNear:   cfg_prdata = {1'b0, near_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // zero near plane is treated as one LSB so the divide never sees zero
  always_comb begin
    cfg.focal  = focal_r;
    cfg.width  = width_r;
    cfg.height = height_r;
    cfg.nearv  = (near_r == '0) ? 31'd1 : near_r;
  end

  job_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;

  npc_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .nearv  (cfg.nearv),
    .q_data (q_wdata),
    .q_push (q_push),
    .q_full (q_full)
  );

  npc_job_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_data (q_wdata),
    .push    (q_push),
    .full    (q_full),
    .rd_data (q_rdata),
    .pop     (q_pop),
    .empty   (q_empty)
  );

  npc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
